FILE: rtl/acslru_pkg.sv
// ----------------------------------------------------------------------------
// acslru_pkg
// Shared types and codes for the access-count segmented LRU page directory.
// ----------------------------------------------------------------------------
`default_nettype none

package acslru_pkg;

    // field widths
    localparam int STREAM_W  = 4;
    localparam int PAGE_W    = 32;
    localparam int BITMAP_W  = 16;
    localparam int CONTENT_W = 64;
    localparam int TIME_W    = 64;
    localparam int SSTATE_W  = 2;
    localparam int OPC_W     = 3;
    localparam int STATUS_W  = 3;
    localparam int OLEVEL_W  = 3;
    localparam int CNT_W     = 7;   // occupancy and level fill
    localparam int CAP_W     = 7;
    localparam int LVCFG_W   = 4;

    // stream widths
    localparam int IN_TDATA_W  = 184;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 200;
    localparam int OUT_TUSER_W = 4;

    // register indexes
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_LEVELS   = 1'b1;

    // opcodes
    localparam logic [OPC_W-1:0] OP_EXISTS    = 3'd0;
    localparam logic [OPC_W-1:0] OP_GET       = 3'd1;
    localparam logic [OPC_W-1:0] OP_INS_READ  = 3'd2;
    localparam logic [OPC_W-1:0] OP_INS_WRITE = 3'd3;
    localparam logic [OPC_W-1:0] OP_UPDATE    = 3'd4;
    localparam logic [OPC_W-1:0] OP_MARK_WB   = 3'd5;
    localparam logic [OPC_W-1:0] OP_REMOVE    = 3'd6;
    localparam logic [OPC_W-1:0] OP_EVICT     = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_EVICT = 3'd4;

    // slot states
    localparam logic [SSTATE_W-1:0] SS_CLEAN = 2'd0;
    localparam logic [SSTATE_W-1:0] SS_DIRTY = 2'd1;
    localparam logic [SSTATE_W-1:0] SS_WB    = 2'd2;

    // page payload of one slot
    typedef struct packed {
        logic [STREAM_W-1:0]  stream;
        logic [PAGE_W-1:0]    page;
        logic [BITMAP_W-1:0]  bitmap;
        logic [CONTENT_W-1:0] content;
        logic [TIME_W-1:0]    stamp;
        logic [SSTATE_W-1:0]  sstate;
    } slot_data_t;

endpackage

`default_nettype wire

FILE: rtl/acslru_ram.sv
// ----------------------------------------------------------------------------
// acslru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module acslru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/acslru_div.sv
// ----------------------------------------------------------------------------
// acslru_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module acslru_div #(
    parameter int W = 7
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic      [W-1:0] quotient,
    output logic              busy
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          fits;

    // shift in next dividend bit and try subtract
    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[W-1:0] : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;

endmodule

`default_nettype wire

FILE: rtl/access_count_segmented_lru_cache.sv
// ----------------------------------------------------------------------------
// access_count_segmented_lru_cache
// Fully associative page directory with per-level recency lists kept in one
// slot memory; a sequencer scans keys and relinks list entries.
// ----------------------------------------------------------------------------
// Flow: a level-share divide, then a key scan of the slot memory, then list
//   relinking (a promote with a demote is the longest); evict skips the scan.
//   One item in flight; the next beat is taken as soon as the result sits in
//   the output register.
// Reset: valid bits, level fills, occupancy and handshake clear at once;
//   capacity 64, 4 levels. No clearing pass.
`default_nettype none

module access_count_segmented_lru_cache
    import acslru_pkg::*;
#(
    parameter int SLOTS            = 64,
    parameter int MAX_LEVELS       = 8,
    parameter int SECTORS_PER_PAGE = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // stream in
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // stream_id, page_number, content, time_stamp, sector_bitmap, pad
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // opcode
    input  wire logic [IN_TUSER_W-1:0]  s_tuser,
    // stream out
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // out_stream, out_page, out_bitmap, out_content, out_time,
    // out_slot_state, out_level, occupancy, is_full, pad
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    // hit, status_code
    output logic      [OUT_TUSER_W-1:0] m_tuser,
    // configuration
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_addr,
    input  wire logic [CAP_W-1:0]       cfg_wdata
);

    localparam int IW     = $clog2(SLOTS);
    localparam int ISS_W  = IW + 1;
    localparam int LVW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int NLW    = $clog2(MAX_LEVELS + 1);
    localparam int CAPP_W = CAP_W + NLW;
    localparam int PW     = 2 * NLW;
    localparam int DW     = (CAP_W > PW) ? CAP_W : PW;
    localparam logic [BITMAP_W-1:0] SECT_MASK = (SECTORS_PER_PAGE >= BITMAP_W) ?
        {BITMAP_W{1'b1}} : BITMAP_W'((64'd1 << SECTORS_PER_PAGE) - 64'd1);

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DIV    = 5'd1;
    localparam logic [4:0] S_SCAN   = 5'd2;
    localparam logic [4:0] S_DECIDE = 5'd3;
    localparam logic [4:0] S_LVS    = 5'd4;
    localparam logic [4:0] S_LOAD   = 5'd5;
    localparam logic [4:0] S_LOADW  = 5'd6;
    localparam logic [4:0] S_U0     = 5'd7;
    localparam logic [4:0] S_U1     = 5'd8;
    localparam logic [4:0] S_U2     = 5'd9;
    localparam logic [4:0] S_U3     = 5'd10;
    localparam logic [4:0] S_UDONE  = 5'd11;
    localparam logic [4:0] S_P0     = 5'd12;
    localparam logic [4:0] S_P1     = 5'd13;
    localparam logic [4:0] S_P2     = 5'd14;
    localparam logic [4:0] S_PDONE  = 5'd15;
    localparam logic [4:0] S_REPORT = 5'd16;
    localparam logic [4:0] S_EMIT   = 5'd17;

    // what the current relink belongs to
    localparam logic [2:0] CTX_PROMO  = 3'd0;
    localparam logic [2:0] CTX_DEMOTE = 3'd1;
    localparam logic [2:0] CTX_REMOVE = 3'd2;
    localparam logic [2:0] CTX_EVICT  = 3'd3;
    localparam logic [2:0] CTX_MARK   = 3'd4;
    localparam logic [2:0] CTX_INS    = 3'd5;

    typedef struct packed {
        slot_data_t      d;
        logic [LVW-1:0]  lvl;
        logic [IW-1:0]   prv;
        logic [IW-1:0]   nxt;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

    // configuration
    logic [CAP_W-1:0]   cap_cfg_reg;
    logic [LVCFG_W-1:0] lvl_cfg_reg;
    logic [CAP_W-1:0]   eff_cap;
    logic [NLW-1:0]     nl;
    logic [PW-1:0]      nl_prod;
    logic [PW-1:0]      share;

    // sequencer registers
    logic [4:0]            state_reg, state_next;
    logic [OPC_W-1:0]      op_reg, op_next;
    logic [STREAM_W-1:0]   key_stream_reg, key_stream_next;
    logic [PAGE_W-1:0]     key_page_reg, key_page_next;
    logic [CONTENT_W-1:0]  in_content_reg, in_content_next;
    logic [TIME_W-1:0]     in_time_reg, in_time_next;
    logic [BITMAP_W-1:0]   in_bitmap_reg, in_bitmap_next;
    logic [CAP_W-1:0]      base_reg, base_next;
    logic [ISS_W-1:0]      iss_reg, iss_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                  found_reg, found_next;
    logic [IW-1:0]         hit_slot_reg, hit_slot_next;
    logic                  free_found_reg, free_found_next;
    logic [IW-1:0]         free_slot_reg, free_slot_next;
    entry_t                wk_reg, wk_next;
    logic [IW-1:0]         wk_slot_reg, wk_slot_next;
    logic [2:0]            ctx_reg, ctx_next;
    logic [LVW-1:0]        tgt_reg, tgt_next;
    logic [LVW-1:0]        orig_lv_reg, orig_lv_next;
    logic                  promo_reg, promo_next;
    logic [NLW-1:0]        lvs_reg, lvs_next;
    logic [CAPP_W-1:0]     capr_reg, capr_next;
    logic [IW-1:0]         rpt_slot_reg, rpt_slot_next;
    logic                  rpt_has_reg, rpt_has_next;
    logic                  hit_reg, hit_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [CNT_W-1:0]      held_reg, held_next;
    logic                  out_vld_reg, out_vld_next;
    logic [OUT_TDATA_W-1:0] out_tdata_reg, out_tdata_next;
    logic [OUT_TUSER_W-1:0] out_tuser_reg, out_tuser_next;

    // level table and valid bits
    logic [CNT_W-1:0] fill_reg [MAX_LEVELS];
    logic [IW-1:0]    head_reg [MAX_LEVELS];
    logic [IW-1:0]    tail_reg [MAX_LEVELS];
    logic             valid_reg [SLOTS];

    logic             fill_we, head_we, tail_we, valid_we, valid_wd;
    logic [LVW-1:0]   fill_wa, head_wa, tail_wa;
    logic [CNT_W-1:0] fill_wd;
    logic [IW-1:0]    head_wd, tail_wd, valid_wa;

    // memory port
    logic             ram_we, ram_re;
    logic [IW-1:0]    ram_waddr, ram_raddr;
    logic [ENT_W-1:0] ram_wdata, ram_rdata;
    entry_t           rd_e;
    entry_t           nb_e;

    // divider
    logic             div_start, div_busy;
    logic [DW-1:0]    div_q;

    // helpers
    logic [LVW-1:0]    lv_u;
    logic [NLW-1:0]    lvp1;
    logic [CAPP_W-1:0] cap_tgt;
    logic              accept;

    // effective configuration
    always_comb
    begin
        if (cap_cfg_reg == '0)
        begin
            eff_cap = CAP_W'(1);
        end
        else if (32'(cap_cfg_reg) > SLOTS)
        begin
            eff_cap = CAP_W'(SLOTS);
        end
        else
        begin
            eff_cap = cap_cfg_reg;
        end
        if (lvl_cfg_reg < LVCFG_W'(2))
        begin
            nl = NLW'(2);
        end
        else if (32'(lvl_cfg_reg) > MAX_LEVELS)
        begin
            nl = NLW'(MAX_LEVELS);
        end
        else
        begin
            nl = NLW'(lvl_cfg_reg);
        end
    end

    assign nl_prod = PW'(nl) * PW'(nl - NLW'(1));
    assign share   = nl_prod >> 1;

    acslru_div #(
        .W (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DW'(eff_cap)),
        .divisor  (DW'(share)),
        .quotient (div_q),
        .busy     (div_busy)
    );

    acslru_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_e    = entry_t'(ram_rdata);
    assign lv_u    = wk_reg.lvl;
    assign lvp1    = NLW'(wk_reg.lvl) + NLW'(1);
    assign cap_tgt = CAPP_W'(base_reg) * CAPP_W'(nl - NLW'(tgt_reg));
    assign accept  = s_tvalid && s_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_tuser_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_stream_next = key_stream_reg;
        key_page_next   = key_page_reg;
        in_content_next = in_content_reg;
        in_time_next    = in_time_reg;
        in_bitmap_next  = in_bitmap_reg;
        base_next       = base_reg;
        iss_next        = iss_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        hit_slot_next   = hit_slot_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        wk_next         = wk_reg;
        wk_slot_next    = wk_slot_reg;
        ctx_next        = ctx_reg;
        tgt_next        = tgt_reg;
        orig_lv_next    = orig_lv_reg;
        promo_next      = promo_reg;
        lvs_next        = lvs_reg;
        capr_next       = capr_reg;
        rpt_slot_next   = rpt_slot_reg;
        rpt_has_next    = rpt_has_reg;
        hit_next        = hit_reg;
        status_next     = status_reg;
        held_next       = held_reg;
        out_vld_next    = out_vld_reg && !m_tready;
        out_tdata_next  = out_tdata_reg;
        out_tuser_next  = out_tuser_reg;

        ram_we    = 1'b0;
        ram_waddr = wk_slot_reg;
        ram_wdata = ENT_W'(wk_reg);
        ram_re    = 1'b0;
        ram_raddr = wk_slot_reg;
        nb_e      = rd_e;

        fill_we  = 1'b0;
        fill_wa  = lv_u;
        fill_wd  = fill_reg[lv_u];
        head_we  = 1'b0;
        head_wa  = lv_u;
        head_wd  = wk_slot_reg;
        tail_we  = 1'b0;
        tail_wa  = lv_u;
        tail_wd  = wk_slot_reg;
        valid_we = 1'b0;
        valid_wa = wk_slot_reg;
        valid_wd = 1'b0;
        div_start = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = s_tuser[OPC_W-1:0];
                    key_stream_next = s_tdata[3:0];
                    key_page_next   = s_tdata[35:4];
                    in_content_next = s_tdata[99:36];
                    in_time_next    = s_tdata[163:100];
                    in_bitmap_next  = s_tdata[179:164] & SECT_MASK;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    iss_next        = '0;
                    div_start       = 1'b1;
                    state_next      = S_DIV;
                end
            end

            // wait for the per-level share
            S_DIV:
            begin
                if (!div_busy)
                begin
                    base_next = CAP_W'(div_q);
                    if (op_reg == OP_EVICT)
                    begin
                        if (fill_reg[0] == '0)
                        begin
                            hit_next     = 1'b0;
                            status_next  = ST_NO_EVICT;
                            rpt_has_next = 1'b0;
                            state_next   = S_EMIT;
                        end
                        else
                        begin
                            wk_slot_next  = tail_reg[0];
                            rpt_slot_next = tail_reg[0];
                            ctx_next      = CTX_EVICT;
                            hit_next      = 1'b1;
                            status_next   = ST_OK;
                            rpt_has_next  = 1'b1;
                            state_next    = S_LOAD;
                        end
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            // key scan, one slot read per cycle
            S_SCAN:
            begin
                if (iss_reg < ISS_W'(SLOTS))
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = iss_reg[IW-1:0];
                    iss_next     = iss_reg + ISS_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = iss_reg[IW-1:0];
                end
                if (cmp_vld_reg)
                begin
                    if (valid_reg[cmp_idx_reg] && !found_reg &&
                        rd_e.d.stream == key_stream_reg && rd_e.d.page == key_page_reg)
                    begin
                        found_next    = 1'b1;
                        hit_slot_next = cmp_idx_reg;
                    end
                    if (!valid_reg[cmp_idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == IW'(SLOTS - 1))
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                rpt_slot_next = hit_slot_reg;
                wk_slot_next  = hit_slot_reg;
                hit_next      = found_reg;
                status_next   = ST_OK;
                rpt_has_next  = found_reg;
                case (op_reg)
                    OP_EXISTS:
                    begin
                        state_next = found_reg ? S_REPORT : S_EMIT;
                    end
                    OP_INS_READ, OP_INS_WRITE:
                    begin
                        if (found_reg)
                        begin
                            status_next = ST_DUP;
                            state_next  = S_REPORT;
                        end
                        else if (held_reg >= eff_cap || !free_found_reg)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_EMIT;
                        end
                        else
                        begin
                            wk_next.d.stream  = key_stream_reg;
                            wk_next.d.page    = key_page_reg;
                            wk_next.d.bitmap  = in_bitmap_reg;
                            wk_next.d.content = in_content_reg;
                            wk_next.d.stamp   = in_time_reg;
                            wk_next.d.sstate  = (op_reg == OP_INS_WRITE) ? SS_DIRTY : SS_CLEAN;
                            wk_slot_next      = free_slot_reg;
                            rpt_slot_next     = free_slot_reg;
                            rpt_has_next      = 1'b1;
                            valid_we          = 1'b1;
                            valid_wa          = free_slot_reg;
                            valid_wd          = 1'b1;
                            held_next         = held_reg + CNT_W'(1);
                            ctx_next          = CTX_INS;
                            lvs_next          = '0;
                            capr_next         = CAPP_W'(base_reg) * CAPP_W'(nl);
                            state_next        = S_LVS;
                        end
                    end
                    OP_GET, OP_UPDATE, OP_MARK_WB, OP_REMOVE:
                    begin
                        if (!found_reg)
                        begin
                            status_next = ST_MISSING;
                            state_next  = S_EMIT;
                        end
                        else
                        begin
                            if (op_reg == OP_MARK_WB)
                            begin
                                ctx_next = CTX_MARK;
                            end
                            else if (op_reg == OP_REMOVE)
                            begin
                                ctx_next = CTX_REMOVE;
                            end
                            else
                            begin
                                ctx_next = CTX_PROMO;
                            end
                            state_next = S_LOAD;
                        end
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end

            // lowest level not at capacity, one level per cycle
            S_LVS:
            begin
                if (lvs_reg < nl &&
                    CAPP_W'(fill_reg[lvs_reg[LVW-1:0]]) == capr_reg)
                begin
                    lvs_next  = lvs_reg + NLW'(1);
                    capr_next = capr_reg - CAPP_W'(base_reg);
                end
                else
                begin
                    tgt_next   = (lvs_reg >= nl) ? '0 : lvs_reg[LVW-1:0];
                    state_next = S_P0;
                end
            end

            S_LOAD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = wk_slot_reg;
                state_next = S_LOADW;
            end

            S_LOADW:
            begin
                wk_next = rd_e;
                if (ctx_reg == CTX_MARK)
                begin
                    wk_next.d.sstate = SS_WB;
                    state_next       = S_P2;
                end
                else
                begin
                    if (ctx_reg == CTX_PROMO && op_reg == OP_UPDATE)
                    begin
                        wk_next.d.bitmap  = in_bitmap_reg;
                        wk_next.d.content = in_content_reg;
                        wk_next.d.stamp   = in_time_reg;
                        wk_next.d.sstate  = SS_DIRTY;
                    end
                    state_next = S_U0;
                end
            end

            // unlink: head side
            S_U0:
            begin
                if (fill_reg[lv_u] <= CNT_W'(1))
                begin
                    fill_we    = 1'b1;
                    fill_wd    = '0;
                    state_next = S_UDONE;
                end
                else if (head_reg[lv_u] == wk_slot_reg)
                begin
                    head_we    = 1'b1;
                    head_wd    = wk_reg.nxt;
                    state_next = S_U2;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = wk_reg.prv;
                    state_next = S_U1;
                end
            end

            S_U1:
            begin
                nb_e.nxt   = wk_reg.nxt;
                ram_we     = 1'b1;
                ram_waddr  = wk_reg.prv;
                ram_wdata  = ENT_W'(nb_e);
                state_next = S_U2;
            end

            // unlink: tail side
            S_U2:
            begin
                if (tail_reg[lv_u] == wk_slot_reg)
                begin
                    tail_we    = 1'b1;
                    tail_wd    = wk_reg.prv;
                    fill_we    = 1'b1;
                    fill_wd    = fill_reg[lv_u] - CNT_W'(1);
                    state_next = S_UDONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = wk_reg.nxt;
                    state_next = S_U3;
                end
            end

            S_U3:
            begin
                nb_e.prv   = wk_reg.prv;
                ram_we     = 1'b1;
                ram_waddr  = wk_reg.nxt;
                ram_wdata  = ENT_W'(nb_e);
                fill_we    = 1'b1;
                fill_wd    = fill_reg[lv_u] - CNT_W'(1);
                state_next = S_UDONE;
            end

            S_UDONE:
            begin
                case (ctx_reg)
                    CTX_PROMO:
                    begin
                        orig_lv_next = wk_reg.lvl;
                        if (lvp1 >= nl)
                        begin
                            tgt_next   = wk_reg.lvl;
                            promo_next = 1'b0;
                        end
                        else
                        begin
                            tgt_next   = lvp1[LVW-1:0];
                            promo_next = 1'b1;
                        end
                        state_next = S_P0;
                    end
                    CTX_DEMOTE:
                    begin
                        state_next = S_P0;
                    end
                    CTX_REMOVE, CTX_EVICT:
                    begin
                        valid_we = 1'b1;
                        valid_wa = wk_slot_reg;
                        valid_wd = 1'b0;
                        if (held_reg != '0)
                        begin
                            held_next = held_reg - CNT_W'(1);
                        end
                        state_next = S_REPORT;
                    end
                    default:
                    begin
                        state_next = S_REPORT;
                    end
                endcase
            end

            // push to most recent end of level tgt
            S_P0:
            begin
                wk_next.lvl = tgt_reg;
                wk_next.prv = wk_slot_reg;
                fill_wa     = tgt_reg;
                head_wa     = tgt_reg;
                tail_wa     = tgt_reg;
                if (fill_reg[tgt_reg] == '0)
                begin
                    wk_next.nxt = wk_slot_reg;
                    head_we     = 1'b1;
                    tail_we     = 1'b1;
                    fill_we     = 1'b1;
                    fill_wd     = CNT_W'(1);
                    state_next  = S_P2;
                end
                else
                begin
                    wk_next.nxt = head_reg[tgt_reg];
                    ram_re      = 1'b1;
                    ram_raddr   = head_reg[tgt_reg];
                    state_next  = S_P1;
                end
            end

            S_P1:
            begin
                nb_e.prv   = wk_slot_reg;
                ram_we     = 1'b1;
                ram_waddr  = head_reg[tgt_reg];
                ram_wdata  = ENT_W'(nb_e);
                head_we    = 1'b1;
                head_wa    = tgt_reg;
                fill_we    = 1'b1;
                fill_wa    = tgt_reg;
                fill_wd    = fill_reg[tgt_reg] + CNT_W'(1);
                state_next = S_P2;
            end

            S_P2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = wk_slot_reg;
                ram_wdata  = ENT_W'(wk_reg);
                state_next = S_PDONE;
            end

            // after a promote, demote the upper level's oldest if full
            S_PDONE:
            begin
                if (ctx_reg == CTX_PROMO && promo_reg &&
                    CAPP_W'(fill_reg[tgt_reg]) >= cap_tgt)
                begin
                    wk_slot_next = tail_reg[tgt_reg];
                    tgt_next     = orig_lv_reg;
                    ctx_next     = CTX_DEMOTE;
                    state_next   = S_LOAD;
                end
                else
                begin
                    state_next = S_REPORT;
                end
            end

            S_REPORT:
            begin
                ram_re     = 1'b1;
                ram_raddr  = rpt_slot_reg;
                state_next = S_EMIT;
            end

            // result beat into the output register
            S_EMIT:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next   = 1'b1;
                    out_tuser_next = {status_reg, hit_reg};
                    if (rpt_has_reg)
                    begin
                        out_tdata_next = {7'd0, (held_reg == eff_cap), held_reg,
                                          OLEVEL_W'(rd_e.lvl), rd_e.d.sstate,
                                          rd_e.d.stamp, rd_e.d.content, rd_e.d.bitmap,
                                          rd_e.d.page, rd_e.d.stream};
                    end
                    else
                    begin
                        out_tdata_next = {7'd0, (held_reg == eff_cap), held_reg,
                                          OLEVEL_W'(0), SS_CLEAN, 64'd0, 64'd0, 16'd0,
                                          32'd0, 4'd0};
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cmp_vld_reg <= 1'b0;
            held_reg    <= '0;
            out_vld_reg <= 1'b0;
            cap_cfg_reg <= CAP_W'(64);
            lvl_cfg_reg <= LVCFG_W'(4);
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                fill_reg[i] <= '0;
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            held_reg    <= held_next;
            out_vld_reg <= out_vld_next;
            if (cfg_we && cfg_addr == REG_CAPACITY)
            begin
                cap_cfg_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr == REG_LEVELS)
            begin
                lvl_cfg_reg <= cfg_wdata[LVCFG_W-1:0];
            end
            if (fill_we)
            begin
                fill_reg[fill_wa] <= fill_wd;
            end
            if (valid_we)
            begin
                valid_reg[valid_wa] <= valid_wd;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_stream_reg <= key_stream_next;
        key_page_reg   <= key_page_next;
        in_content_reg <= in_content_next;
        in_time_reg    <= in_time_next;
        in_bitmap_reg  <= in_bitmap_next;
        base_reg       <= base_next;
        iss_reg        <= iss_next;
        cmp_idx_reg    <= cmp_idx_next;
        found_reg      <= found_next;
        hit_slot_reg   <= hit_slot_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        wk_reg         <= wk_next;
        wk_slot_reg    <= wk_slot_next;
        ctx_reg        <= ctx_next;
        tgt_reg        <= tgt_next;
        orig_lv_reg    <= orig_lv_next;
        promo_reg      <= promo_next;
        lvs_reg        <= lvs_next;
        capr_reg       <= capr_next;
        rpt_slot_reg   <= rpt_slot_next;
        rpt_has_reg    <= rpt_has_next;
        hit_reg        <= hit_next;
        status_reg     <= status_next;
        out_tdata_reg  <= out_tdata_next;
        out_tuser_reg  <= out_tuser_next;
        if (head_we)
        begin
            head_reg[head_wa] <= head_wd;
        end
        if (tail_we)
        begin
            tail_reg[tail_wa] <= tail_wd;
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_access_count_segmented_lru_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_access_count_segmented_lru_cache
// Self-checking bench for the segmented LRU page directory. Every beat taken
// on the input stream is run through a local copy of the directory (slots,
// per-level recency lists, fills) and the predicted result beat is queued.
// Output beats are compared field by field against that queue. The run
// covers directed corner cases, then random traffic over several capacity
// and level settings under changing backpressure.
// ----------------------------------------------------------------------------
module tb_access_count_segmented_lru_cache;
    import acslru_pkg::*;

    localparam int NSLOT      = 64;
    localparam int NLEVEL     = 8;
    localparam int DRAIN_WAIT = NSLOT + 40;
    localparam int CYCLE_CAP  = 3000000;

    // result beat field offsets, lowest bit up
    localparam int O_STREAM = 0;
    localparam int O_PAGE   = 4;
    localparam int O_BITMAP = 36;
    localparam int O_CONT   = 52;
    localparam int O_TIME   = 116;
    localparam int O_SSTATE = 180;
    localparam int O_LEVEL  = 182;
    localparam int O_OCC    = 185;
    localparam int O_FULL   = 192;

    typedef struct {
        logic                 hit;
        logic [STATUS_W-1:0]  status;
        logic [STREAM_W-1:0]  stream;
        logic [PAGE_W-1:0]    page;
        logic [BITMAP_W-1:0]  bitmap;
        logic [CONTENT_W-1:0] content;
        logic [TIME_W-1:0]    stamp;
        logic [SSTATE_W-1:0]  sstate;
        logic [OLEVEL_W-1:0]  level;
        logic [CNT_W-1:0]     occ;
        logic                 full;
    } dir_result_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [IN_TUSER_W-1:0]  s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic cfg_we;
    logic cfg_addr;
    logic [CAP_W-1:0] cfg_wdata;

    access_count_segmented_lru_cache u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // shadow directory
    bit                   sh_valid [NSLOT];
    logic [STREAM_W-1:0]  sh_stream [NSLOT];
    logic [PAGE_W-1:0]    sh_page [NSLOT];
    logic [BITMAP_W-1:0]  sh_bitmap [NSLOT];
    logic [CONTENT_W-1:0] sh_content [NSLOT];
    logic [TIME_W-1:0]    sh_stamp [NSLOT];
    logic [SSTATE_W-1:0]  sh_sstate [NSLOT];
    int                   sh_level [NSLOT];
    int                   sh_prev [NSLOT];
    int                   sh_next [NSLOT];
    int                   lv_head [NLEVEL];
    int                   lv_tail [NLEVEL];
    int                   lv_fill [NLEVEL];
    int                   held;
    int                   cap_reg;
    int                   lvl_reg;

    dir_result_t pending_results[$];

    // key pool so random traffic hits often
    logic [STREAM_W-1:0] pool_stream [24];
    logic [PAGE_W-1:0]   pool_page [24];

    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold;
    int fail_count;
    int beats_in;
    int beats_out;
    int hit_count;
    int full_count;
    int noevict_count;
    int cfg_count;
    int cycle_count;

    // clock and cycle limit
    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls plus a counted long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (recv_hold > 0)
        begin
            m_tready  <= 1'b0;
            recv_hold <= recv_hold - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ---- predictor ----
    function automatic int cap_eff();
        if (cap_reg < 1) return 1;
        if (cap_reg > NSLOT) return NSLOT;
        return cap_reg;
    endfunction

    function automatic int levels_eff();
        if (lvl_reg < 2) return 2;
        if (lvl_reg > NLEVEL) return NLEVEL;
        return lvl_reg;
    endfunction

    function automatic int level_cap(int lv);
        int nl;
        int share;
        nl = levels_eff();
        share = nl * (nl - 1) / 2;
        if (lv >= nl) return 0;
        return (cap_eff() / share) * (nl - lv);
    endfunction

    function automatic int lookup(logic [STREAM_W-1:0] st, logic [PAGE_W-1:0] pg);
        for (int i = 0; i < NSLOT; i++)
            if (sh_valid[i] && sh_stream[i] == st && sh_page[i] == pg)
                return i;
        return -1;
    endfunction

    function automatic void detach(int s);
        int lv;
        int p;
        int n;
        lv = sh_level[s];
        p = sh_prev[s];
        n = sh_next[s];
        if (lv_fill[lv] <= 1)
        begin
            lv_fill[lv] = 0;
            return;
        end
        if (lv_head[lv] == s) lv_head[lv] = n;
        else sh_next[p] = n;
        if (lv_tail[lv] == s) lv_tail[lv] = p;
        else sh_prev[n] = p;
        lv_fill[lv]--;
    endfunction

    function automatic void attach_mru(int lv, int s);
        sh_level[s] = lv;
        sh_prev[s] = s;
        if (lv_fill[lv] == 0)
        begin
            sh_next[s] = s;
            lv_head[lv] = s;
            lv_tail[lv] = s;
        end
        else
        begin
            sh_next[s] = lv_head[lv];
            sh_prev[lv_head[lv]] = s;
            lv_head[lv] = s;
        end
        lv_fill[lv]++;
    endfunction

    // hit: move up one level, demote that level's LRU entry when full
    function automatic void promote_hit(int s);
        int lv;
        int t;
        lv = sh_level[s];
        detach(s);
        if (lv + 1 >= levels_eff())
        begin
            attach_mru(lv, s);
            return;
        end
        attach_mru(lv + 1, s);
        if (lv_fill[lv + 1] >= level_cap(lv + 1))
        begin
            t = lv_tail[lv + 1];
            detach(t);
            attach_mru(lv, t);
        end
    endfunction

    function automatic dir_result_t make_result(logic hit, logic [STATUS_W-1:0] status,
                                                int s, int lv);
        dir_result_t r;
        r = '{default: '0};
        r.hit = hit;
        r.status = status;
        if (s >= 0)
        begin
            r.stream  = sh_stream[s];
            r.page    = sh_page[s];
            r.bitmap  = sh_bitmap[s];
            r.content = sh_content[s];
            r.stamp   = sh_stamp[s];
            r.sstate  = sh_sstate[s];
            r.level   = lv[OLEVEL_W-1:0];
        end
        r.occ  = held[CNT_W-1:0];
        r.full = (held == cap_eff());
        return r;
    endfunction

    function automatic dir_result_t apply_op(logic [OPC_W-1:0] opc,
                                             logic [STREAM_W-1:0] st,
                                             logic [PAGE_W-1:0] pg,
                                             logic [CONTENT_W-1:0] cont,
                                             logic [TIME_W-1:0] stamp,
                                             logic [BITMAP_W-1:0] bm);
        int s;
        int f;
        int lv;
        int t;
        s = (opc == OP_EVICT) ? -1 : lookup(st, pg);
        case (opc)
            OP_EXISTS:
                return (s < 0) ? make_result(1'b0, ST_OK, -1, 0)
                               : make_result(1'b1, ST_OK, s, sh_level[s]);
            OP_INS_READ, OP_INS_WRITE:
            begin
                if (s >= 0) return make_result(1'b1, ST_DUP, s, sh_level[s]);
                f = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (!sh_valid[i] && f < 0) f = i;
                if (held >= cap_eff() || f < 0) return make_result(1'b0, ST_FULL, -1, 0);
                sh_valid[f]   = 1'b1;
                sh_stream[f]  = st;
                sh_page[f]    = pg;
                sh_bitmap[f]  = bm;
                sh_content[f] = cont;
                sh_stamp[f]   = stamp;
                sh_sstate[f]  = (opc == OP_INS_WRITE) ? SS_DIRTY : SS_CLEAN;
                lv = 0;
                while (lv < levels_eff() && lv_fill[lv] == level_cap(lv)) lv++;
                if (lv >= levels_eff()) lv = 0;
                attach_mru(lv, f);
                held++;
                return make_result(1'b0, ST_OK, f, sh_level[f]);
            end
            OP_GET, OP_UPDATE:
            begin
                if (s < 0) return make_result(1'b0, ST_MISSING, -1, 0);
                if (opc == OP_UPDATE)
                begin
                    sh_bitmap[s]  = bm;
                    sh_content[s] = cont;
                    sh_stamp[s]   = stamp;
                    sh_sstate[s]  = SS_DIRTY;
                end
                promote_hit(s);
                return make_result(1'b1, ST_OK, s, sh_level[s]);
            end
            OP_MARK_WB:
            begin
                if (s < 0) return make_result(1'b0, ST_MISSING, -1, 0);
                sh_sstate[s] = SS_WB;
                return make_result(1'b1, ST_OK, s, sh_level[s]);
            end
            OP_REMOVE:
            begin
                if (s < 0) return make_result(1'b0, ST_MISSING, -1, 0);
                detach(s);
                sh_valid[s] = 1'b0;
                held--;
                return make_result(1'b1, ST_OK, s, sh_level[s]);
            end
            default:
            begin
                if (lv_fill[0] == 0) return make_result(1'b0, ST_NO_EVICT, -1, 0);
                t = lv_tail[0];
                detach(t);
                sh_valid[t] = 1'b0;
                if (held > 0) held--;
                return make_result(1'b1, ST_OK, t, 0);
            end
        endcase
    endfunction

    // ---- result checker ----
    always @(posedge clk)
    begin
        dir_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_out++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: tdata=%h tuser=%h", m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (m_tuser[0] !== e.hit)
                begin
                    $error("hit: expected %h, got %h", e.hit, m_tuser[0]); fail_count++;
                end
                if (m_tuser[3:1] !== e.status)
                begin
                    $error("status_code: expected %h, got %h", e.status, m_tuser[3:1]);
                    fail_count++;
                end
                if (m_tdata[O_STREAM +: STREAM_W] !== e.stream)
                begin
                    $error("out_stream: expected %h, got %h", e.stream,
                           m_tdata[O_STREAM +: STREAM_W]); fail_count++;
                end
                if (m_tdata[O_PAGE +: PAGE_W] !== e.page)
                begin
                    $error("out_page: expected %h, got %h", e.page,
                           m_tdata[O_PAGE +: PAGE_W]); fail_count++;
                end
                if (m_tdata[O_BITMAP +: BITMAP_W] !== e.bitmap)
                begin
                    $error("out_bitmap: expected %h, got %h", e.bitmap,
                           m_tdata[O_BITMAP +: BITMAP_W]); fail_count++;
                end
                if (m_tdata[O_CONT +: CONTENT_W] !== e.content)
                begin
                    $error("out_content: expected %h, got %h", e.content,
                           m_tdata[O_CONT +: CONTENT_W]); fail_count++;
                end
                if (m_tdata[O_TIME +: TIME_W] !== e.stamp)
                begin
                    $error("out_time: expected %h, got %h", e.stamp,
                           m_tdata[O_TIME +: TIME_W]); fail_count++;
                end
                if (m_tdata[O_SSTATE +: SSTATE_W] !== e.sstate)
                begin
                    $error("out_slot_state: expected %h, got %h", e.sstate,
                           m_tdata[O_SSTATE +: SSTATE_W]); fail_count++;
                end
                if (m_tdata[O_LEVEL +: OLEVEL_W] !== e.level)
                begin
                    $error("out_level: expected %h, got %h", e.level,
                           m_tdata[O_LEVEL +: OLEVEL_W]); fail_count++;
                end
                if (m_tdata[O_OCC +: CNT_W] !== e.occ)
                begin
                    $error("occupancy: expected %0d, got %0d", e.occ,
                           m_tdata[O_OCC +: CNT_W]); fail_count++;
                end
                if (m_tdata[O_FULL] !== e.full)
                begin
                    $error("is_full: expected %h, got %h", e.full, m_tdata[O_FULL]);
                    fail_count++;
                end
            end
        end
    end

    // ---- stimulus helpers ----
    task automatic send_beat(logic [OPC_W-1:0] opc, logic [STREAM_W-1:0] st,
                             logic [PAGE_W-1:0] pg, logic [CONTENT_W-1:0] cont,
                             logic [TIME_W-1:0] stamp, logic [BITMAP_W-1:0] bm);
        dir_result_t r;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= opc;
        s_tdata  <= {4'd0, bm, stamp, cont, pg, st};
        do @(posedge clk); while (!s_tready);
        r = apply_op(opc, st, pg, cont, stamp, bm);
        pending_results.push_back(r);
        beats_in++;
        if (r.hit) hit_count++;
        if (r.status == ST_FULL) full_count++;
        if (r.status == ST_NO_EVICT) noevict_count++;
    endtask

    // lower valid and wait until the directory is idle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value[CAP_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_CAPACITY) cap_reg = value & 7'h7f;
        else lvl_reg = value & 4'hf;
        cfg_count++;
    endtask

    task automatic set_config(int cap, int lvls);
        drain();
        write_reg(REG_CAPACITY, cap);
        write_reg(REG_LEVELS, lvls);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_random();
        logic [OPC_W-1:0]    opc;
        logic [STREAM_W-1:0] st;
        logic [PAGE_W-1:0]   pg;
        int k;
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) opc = ($urandom_range(1)) ? OP_INS_READ : OP_INS_WRITE;
        else if (pick < 50) opc = OP_GET;
        else if (pick < 62) opc = OP_UPDATE;
        else if (pick < 70) opc = OP_EXISTS;
        else if (pick < 76) opc = OP_MARK_WB;
        else if (pick < 86) opc = OP_REMOVE;
        else opc = OP_EVICT;
        k = $urandom_range(23);
        if ($urandom_range(9) < 8)
        begin
            st = pool_stream[k];
            pg = pool_page[k];
        end
        else
        begin
            st = $urandom;
            pg = $urandom;
        end
        send_beat(opc, st, pg, rand64(), rand64(), $urandom);
    endtask

    // ---- tests ----
    task automatic test_directed();
        logic [63:0] ones;
        ones = '1;
        // empty directory: nothing to evict, misses everywhere
        send_beat(OP_EVICT, 4'd0, 32'd0, 64'd0, 64'd0, 16'd0);
        send_beat(OP_EXISTS, 4'd0, 32'd0, 64'd0, 64'd0, 16'd0);
        send_beat(OP_GET, 4'hf, '1, 64'd0, 64'd0, 16'd0);
        send_beat(OP_UPDATE, 4'd3, 32'd7, ones, ones, '1);
        send_beat(OP_MARK_WB, 4'd3, 32'd7, 64'd0, 64'd0, 16'd0);
        send_beat(OP_REMOVE, 4'd3, 32'd7, 64'd0, 64'd0, 16'd0);
        // field extremes on insert, duplicate insert
        send_beat(OP_INS_READ, 4'd0, 32'd0, 64'd0, 64'd0, 16'd0);
        send_beat(OP_INS_WRITE, 4'hf, '1, ones, ones, '1);
        send_beat(OP_INS_READ, 4'hf, '1, 64'd5, 64'd5, 16'd5);
        send_beat(OP_EXISTS, 4'hf, '1, 64'd0, 64'd0, 16'd0);
        // hits promote, writeback marking, update
        send_beat(OP_GET, 4'd0, 32'd0, 64'd0, 64'd0, 16'd0);
        send_beat(OP_GET, 4'd0, 32'd0, 64'd0, 64'd0, 16'd0);
        send_beat(OP_UPDATE, 4'hf, '1, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                  16'ha5a5);
        send_beat(OP_MARK_WB, 4'd0, 32'd0, 64'd0, 64'd0, 16'd0);
        send_beat(OP_REMOVE, 4'd0, 32'd0, 64'd0, 64'd0, 16'd0);
        send_beat(OP_EVICT, 4'd0, 32'd0, 64'd0, 64'd0, 16'd0);
        send_beat(OP_EVICT, 4'd0, 32'd0, 64'd0, 64'd0, 16'd0);
        // capacity of one: second insert is refused
        set_config(1, 2);
        send_beat(OP_INS_READ, 4'd1, 32'd1, 64'd1, 64'd1, 16'd1);
        send_beat(OP_INS_READ, 4'd2, 32'd2, 64'd2, 64'd2, 16'd2);
        send_beat(OP_GET, 4'd1, 32'd1, 64'd0, 64'd0, 16'd0);
        send_beat(OP_EVICT, 4'd0, 32'd0, 64'd0, 64'd0, 16'd0);
    endtask

    task automatic test_random_phase(int cap, int lvls, int count);
        set_config(cap, lvls);
        for (int i = 0; i < count; i++) send_random();
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        drain();
        send_idle_pct = 0;
        recv_hold <= 400;
        for (int i = 0; i < 40; i++) send_random();
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_addr = 1'b0;
        cfg_wdata = '0;
        recv_hold = 0;
        cycle_count = 0;
        fail_count = 0;
        beats_in = 0;
        beats_out = 0;
        hit_count = 0;
        full_count = 0;
        noevict_count = 0;
        cfg_count = 0;
        held = 0;
        cap_reg = 64;
        lvl_reg = 4;
        send_idle_pct = 7;
        recv_idle_pct = 52;
        foreach (sh_valid[i]) sh_valid[i] = 1'b0;
        foreach (lv_fill[i]) lv_fill[i] = 0;
        for (int i = 0; i < 24; i++)
        begin
            pool_stream[i] = $urandom;
            pool_page[i]   = (i < 12) ? $urandom_range(15) : $urandom;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        // sender busy, receiver quiet
        test_random_phase(64, 8, 260);
        test_random_phase(64, 2, 250);
        test_backpressure();
        // sender quiet, receiver busy
        send_idle_pct = 52;
        recv_idle_pct = 7;
        test_random_phase(12, 3, 250);
        test_random_phase(8, 8, 240);
        // no idling at all
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_phase(37, 5, 250);
        test_random_phase(64, 4, 260);
        drain();

        $display("covered %0d beats in, %0d out, %0d hits, %0d refused inserts,",
                 beats_in, beats_out, hit_count, full_count);
        $display("%0d empty evicts, %0d register writes over 7 settings",
                 noevict_count, cfg_count);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
rtl/acslru_pkg.sv
rtl/acslru_ram.sv
rtl/acslru_div.sv
rtl/access_count_segmented_lru_cache.sv
tb/tb_access_count_segmented_lru_cache.sv
